@@ rtl/core/ptsa_pkg.sv @@
// Package for the peer table: sizes, codes and entry layout.
package ptsa_pkg;

	localparam int PEER_COUNT = 16;
	localparam int IDX_W      = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
	localparam int DATA_W     = 32;
	localparam int SLOT_W     = 4;

	localparam logic [DATA_W-1:0] SERIAL_HALF    = 32'h8000_0000;
	localparam logic [DATA_W-1:0] DIM_RESET      = 32'd3000;
	localparam logic [DATA_W-1:0] STALE_RESET    = 32'd10000;
	localparam logic [DATA_W-1:0] EXPIRE_RESET   = 32'd30000;

	localparam logic [1:0] CFG_DIM    = 2'd0;
	localparam logic [1:0] CFG_STALE  = 2'd1;
	localparam logic [1:0] CFG_EXPIRE = 2'd2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [1:0] {
		FN_UPDATE = 2'd0,
		FN_QUERY  = 2'd1,
		FN_EXPIRE = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STS_INSERTED  = 3'd0,
		STS_REFRESHED = 3'd1,
		STS_IGNORED   = 3'd2,
		STS_FULL      = 3'd3,
		STS_DONE      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_FRESH = 2'd1,
		CLS_DIM   = 2'd2,
		CLS_STALE = 2'd3
	} age_class_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN,
		S_CLASS
	} fsm_t;

	typedef struct packed {
		data_t peer_id;
		data_t prev_seq;
		data_t last_rx;
	} entry_t;

endpackage

@@ rtl/core/ptsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ptsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/peer_table_with_seq_age_unit.sv @@
// Peer table top level: lookup, insert, sequence check, age class and expire.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: func, peer_id,
//   seq_number, now_ms. Output channel (out_valid/out_ready) returns one
//   result per request: status, slot, age_class.
//   Every request scans all PEER_COUNT entries through the entry RAM, one
//   read per cycle, then finishes. The shared 32-bit subtractor gives the
//   serial-number difference for update and the age for expire and for a
//   query that hits; such a query takes an extra class step after finish.
//   in_ready is high only while idle, so one request runs at a time.
//   The result sits in an output register: a new request is taken while it
//   waits, and that request holds in its last step until the register frees.
//   Reset clears all used marks and loads the default thresholds; entry
//   data is rewritten on insert so the RAM needs no clearing pass.
//   cfg_we writes a threshold at once; write only while idle.
module peer_table_with_seq_age_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] peer_id,
	input  logic [31:0] seq_number,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic [1:0]  age_class,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	ptsa_pkg::fsm_t       state_q, state_d;
	ptsa_pkg::func_t      func_q;
	ptsa_pkg::data_t      id_q, seq_q, now_q;
	ptsa_pkg::data_t      dim_q, stale_q, expire_q;
	ptsa_pkg::idx_t       idx_q;
	logic [ptsa_pkg::PEER_COUNT-1:0] used_q;

	logic                 vld_s1, used_s1;
	ptsa_pkg::idx_t       idx_s1;
	logic                 vld_s2;
	ptsa_pkg::idx_t       idx_s2;
	ptsa_pkg::data_t      age_s2;

	logic                 hit_q, free_q;
	ptsa_pkg::idx_t       hit_idx_q, free_idx_q;
	ptsa_pkg::data_t      hit_seq_q, hit_rx_q, age_q;

	logic                 out_valid_q;
	ptsa_pkg::status_t    status_q;
	ptsa_pkg::slot_t      slot_q;
	ptsa_pkg::age_class_t class_q;

	ptsa_pkg::entry_t     rd_entry, wr_entry;
	logic                 ram_we;
	ptsa_pkg::idx_t       ram_waddr;

	ptsa_pkg::data_t      sub_a, sub_b, sub_y;
	logic                 in_acc, out_free, older, match_s1;

	logic                 out_load, set_used, age_load;
	ptsa_pkg::status_t    status_d;
	ptsa_pkg::slot_t      slot_d;
	ptsa_pkg::age_class_t class_d;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign match_s1 = used_s1 && (rd_entry.peer_id == id_q);

	ptsa_ram #(
		.WIDTH ($bits(ptsa_pkg::entry_t)),
		.DEPTH (ptsa_pkg::PEER_COUNT)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	// shared subtractor: age during expire scan, serial diff or age at finish
	always_comb begin
		sub_a = now_q;
		sub_b = rd_entry.last_rx;
		if (state_q == ptsa_pkg::S_FIN) begin
			if (func_q == ptsa_pkg::FN_UPDATE) begin
				sub_a = seq_q;
				sub_b = hit_seq_q;
			end else begin
				sub_b = hit_rx_q;
			end
		end
	end

	assign sub_y = sub_a - sub_b;
	assign older = (sub_y != '0) && (sub_y >= ptsa_pkg::SERIAL_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		set_used  = 1'b0;
		age_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		wr_entry  = '{peer_id: id_q, prev_seq: seq_q, last_rx: now_q};
		status_d  = ptsa_pkg::STS_DONE;
		slot_d    = '0;
		class_d   = ptsa_pkg::CLS_NONE;
		case (state_q)
			ptsa_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = ptsa_pkg::S_SCAN;
				end
			end
			ptsa_pkg::S_SCAN: begin
				if (idx_q == ptsa_pkg::idx_t'(ptsa_pkg::PEER_COUNT - 1)) begin
					state_d = ptsa_pkg::S_DRAIN;
				end
			end
			ptsa_pkg::S_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ptsa_pkg::S_FIN;
				end
			end
			ptsa_pkg::S_FIN: begin
				if (func_q == ptsa_pkg::FN_QUERY && hit_q) begin
					age_load = 1'b1;
					state_d  = ptsa_pkg::S_CLASS;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ptsa_pkg::S_IDLE;
					if (func_q == ptsa_pkg::FN_UPDATE) begin
						if (hit_q) begin
							slot_d = ptsa_pkg::slot_t'(hit_idx_q);
							if (older) begin
								status_d = ptsa_pkg::STS_IGNORED;
							end else begin
								status_d = ptsa_pkg::STS_REFRESHED;
								ram_we   = 1'b1;
							end
						end else if (free_q) begin
							status_d  = ptsa_pkg::STS_INSERTED;
							slot_d    = ptsa_pkg::slot_t'(free_idx_q);
							ram_we    = 1'b1;
							ram_waddr = free_idx_q;
							set_used  = 1'b1;
						end else begin
							status_d = ptsa_pkg::STS_FULL;
						end
					end
				end
			end
			ptsa_pkg::S_CLASS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ptsa_pkg::S_IDLE;
					slot_d   = ptsa_pkg::slot_t'(hit_idx_q);
					if (age_q >= stale_q) begin
						class_d = ptsa_pkg::CLS_STALE;
					end else if (age_q >= dim_q) begin
						class_d = ptsa_pkg::CLS_DIM;
					end else begin
						class_d = ptsa_pkg::CLS_FRESH;
					end
				end
			end
			default: begin
				state_d = ptsa_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			dim_q       <= ptsa_pkg::DIM_RESET;
			stale_q     <= ptsa_pkg::STALE_RESET;
			expire_q    <= ptsa_pkg::EXPIRE_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptsa_pkg::CFG_DIM:    dim_q    <= cfg_wdata;
					ptsa_pkg::CFG_STALE:  stale_q  <= cfg_wdata;
					ptsa_pkg::CFG_EXPIRE: expire_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (in_acc) begin
				idx_q <= '0;
			end else if (state_q == ptsa_pkg::S_SCAN &&
			             idx_q != ptsa_pkg::idx_t'(ptsa_pkg::PEER_COUNT - 1)) begin
				idx_q <= idx_q + 1'b1;
			end

			vld_s1 <= (state_q == ptsa_pkg::S_SCAN);
			vld_s2 <= vld_s1 && used_s1 && (func_q == ptsa_pkg::FN_EXPIRE);

			if (in_acc) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (vld_s1) begin
				if (match_s1 && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!used_s1 && !free_q) begin
					free_q <= 1'b1;
				end
			end

			if (vld_s2 && (age_s2 >= expire_q)) begin
				used_q[idx_s2] <= 1'b0;
			end
			if (set_used) begin
				used_q[free_idx_q] <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= ptsa_pkg::func_t'(func);
			id_q   <= peer_id;
			seq_q  <= seq_number;
			now_q  <= now_ms;
		end
		idx_s1  <= idx_q;
		used_s1 <= used_q[idx_q];
		idx_s2  <= idx_s1;
		age_s2  <= sub_y;
		if (vld_s1 && match_s1 && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_seq_q <= rd_entry.prev_seq;
			hit_rx_q  <= rd_entry.last_rx;
		end
		if (vld_s1 && !used_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (age_load) begin
			age_q <= sub_y;
		end
		if (out_load) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			class_q  <= class_d;
		end
	end

	assign in_ready  = (state_q == ptsa_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign age_class = class_q;

`ifndef SYNTH
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ptsa_pkg::S_SCAN) && (idx_q == '0))
		else $error("accepted request did not start a scan at entry zero");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (status_d == ptsa_pkg::STS_FULL)) |-> (&used_q))
		else $error("table full reported with a free entry");

	a_hit_is_used: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ptsa_pkg::S_FIN) && hit_q && (func_q != ptsa_pkg::FN_EXPIRE))
		|-> used_q[hit_idx_q])
		else $error("matched entry is not in use");

	a_age_stage_expire_only: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (func_q == ptsa_pkg::FN_EXPIRE))
		else $error("expire age stage active outside expire");
`endif

endmodule

@@ tb/tb.sv @@
// Testbench for the peer table unit: own table model, directed and random requests, scoreboard.
module tb;
	import ptsa_pkg::*;

	localparam int POOL        = 24;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		status_t    status;
		slot_t      slot;
		age_class_t age_class;
	} peer_result_t;

	class peer_table_model;
		bit           used [PEER_COUNT];
		data_t        ids  [PEER_COUNT];
		data_t        seqs [PEER_COUNT];
		data_t        rx   [PEER_COUNT];
		data_t        dim_ms;
		data_t        stale_ms;
		data_t        expire_lim;
		peer_result_t pending_replies[$];
		int           errors;

		function new();
			int i;
			for (i = 0; i < PEER_COUNT; i++) begin
				used[i] = 1'b0;
				ids[i]  = '0;
				seqs[i] = '0;
				rx[i]   = '0;
			end
			dim_ms     = DIM_RESET;
			stale_ms   = STALE_RESET;
			expire_lim = EXPIRE_RESET;
			errors     = 0;
		endfunction

		function void set_threshold(logic [1:0] index, data_t value);
			case (index)
				CFG_DIM:    dim_ms = value;
				CFG_STALE:  stale_ms = value;
				CFG_EXPIRE: expire_lim = value;
				default: ;
			endcase
		endfunction

		function int find_peer(data_t id);
			int i;
			for (i = 0; i < PEER_COUNT; i++)
				if (used[i] && ids[i] == id)
					return i;
			return -1;
		endfunction

		function void note_request(logic [1:0] fn, data_t id, data_t seq, data_t now);
			peer_result_t r;
			int           i;
			int           k;
			data_t        diff;
			r.status    = STS_DONE;
			r.slot      = '0;
			r.age_class = CLS_NONE;
			case (fn)
				FN_UPDATE: begin
					i = find_peer(id);
					if (i < 0) begin
						for (k = 0; k < PEER_COUNT && i < 0; k++)
							if (!used[k])
								i = k;
						if (i < 0) begin
							r.status = STS_FULL;
						end else begin
							used[i]  = 1'b1;
							ids[i]   = id;
							seqs[i]  = seq;
							rx[i]    = now;
							r.status = STS_INSERTED;
							r.slot   = slot_t'(i);
						end
					end else begin
						diff   = seq - seqs[i];
						r.slot = slot_t'(i);
						if (seq != seqs[i] && diff >= SERIAL_HALF) begin
							r.status = STS_IGNORED;
						end else begin
							seqs[i]  = seq;
							rx[i]    = now;
							r.status = STS_REFRESHED;
						end
					end
				end
				FN_QUERY: begin
					i = find_peer(id);
					if (i >= 0) begin
						diff   = now - rx[i];
						r.slot = slot_t'(i);
						if (diff >= stale_ms)
							r.age_class = CLS_STALE;
						else if (diff >= dim_ms)
							r.age_class = CLS_DIM;
						else
							r.age_class = CLS_FRESH;
					end
				end
				FN_EXPIRE: begin
					for (k = 0; k < PEER_COUNT; k++) begin
						diff = now - rx[k];
						if (used[k] && diff >= expire_lim)
							used[k] = 1'b0;
					end
				end
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [3:0] sl, logic [1:0] cls);
			peer_result_t r;
			if (pending_replies.size() == 0) begin
				$error("result with no request waiting: status %0d slot %0d age_class %0d",
					st, sl, cls);
				errors++;
			end else begin
				r = pending_replies.pop_front();
				if (st !== r.status) begin
					$error("status: expected %0d, got %0d", r.status, st);
					errors++;
				end
				if (sl !== r.slot) begin
					$error("slot: expected %0d, got %0d", r.slot, sl);
					errors++;
				end
				if (cls !== r.age_class) begin
					$error("age_class: expected %0d, got %0d", r.age_class, cls);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [31:0] peer_id;
	logic [31:0] seq_number;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic [1:0]  age_class;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	peer_table_model book = new();
	bit              idling_on;
	int              quiet_cycles = 0;
	data_t           pool_id  [POOL];
	data_t           pool_seq [POOL];
	data_t           clock_ms;

	peer_table_with_seq_age_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.peer_id    (peer_id),
		.seq_number (seq_number),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.age_class  (age_class),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				book.set_threshold(cfg_index, cfg_wdata);
			if (in_valid && in_ready)
				book.note_request(func, peer_id, seq_number, now_ms);
			if (out_valid && out_ready)
				book.check_result(status, slot, age_class);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
		end
	end

	task automatic send_request(logic [1:0] fn, data_t id, data_t seq, data_t now);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= fn;
		peer_id    <= id;
		seq_number <= seq;
		now_ms     <= now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		while (book.pending_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic load_thresholds(data_t dim, data_t stale, data_t expire);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DIM;
		cfg_wdata <= dim;
		@(negedge clk);
		cfg_index <= CFG_STALE;
		cfg_wdata <= stale;
		@(negedge clk);
		cfg_index <= CFG_EXPIRE;
		cfg_wdata <= expire;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly known peers with plausible sequence steps, some noise
	task automatic random_requests(int count);
		int         n;
		int         k;
		int         pick;
		logic [1:0] fn;
		data_t      id;
		data_t      seq;
		data_t      now;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				fn = FN_UPDATE;
			else if (pick < 85)
				fn = FN_QUERY;
			else if (pick < 93)
				fn = FN_EXPIRE;
			else
				fn = FN_NOP;
			k  = $urandom_range(0, POOL - 1);
			id = ($urandom_range(0, 9) == 0) ? data_t'($urandom) : pool_id[k];
			clock_ms += $urandom_range(0, 600);
			if ($urandom_range(0, 49) == 0)
				clock_ms = $urandom;
			now = clock_ms;
			seq = $urandom;
			if (fn == FN_UPDATE) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						seq = pool_seq[k] + $urandom_range(1, 50);
						pool_seq[k] = seq;
					end
					6: seq = pool_seq[k];
					7: seq = pool_seq[k] - $urandom_range(1, 50);
					8: seq = pool_seq[k] + (($urandom_range(0, 1) == 0) ?
						SERIAL_HALF : SERIAL_HALF - 1);
					default: ;
				endcase
			end else if (fn == FN_QUERY) begin
				now = clock_ms + $urandom_range(0, 15000);
			end
			send_request(fn, id, seq, now);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = FN_UPDATE;
		peer_id    = '0;
		seq_number = '0;
		now_ms     = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_DIM;
		cfg_wdata  = '0;
		idling_on  = 1'b1;
		for (int i = 0; i < POOL; i++) begin
			pool_id[i]  = $urandom;
			pool_seq[i] = $urandom;
		end
		pool_id[0] = '0;
		pool_id[1] = '1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(FN_QUERY,  32'd0, 32'd0, 32'd0);
		send_request(FN_UPDATE, 32'd0, 32'd0, 32'd0);
		send_request(FN_UPDATE, '1, '1, '1);
		send_request(FN_UPDATE, 32'd0, 32'd0, 32'd5);
		send_request(FN_UPDATE, 32'd0, SERIAL_HALF, 32'd10);
		send_request(FN_UPDATE, 32'd0, 32'h7FFF_FFFF, 32'd20);
		send_request(FN_UPDATE, 32'd0, 32'h7FFF_FFFE, 32'd25);
		send_request(FN_QUERY,  32'd0, 32'd0, 32'd20);
		send_request(FN_QUERY,  32'd0, 32'd0, 32'd3019);
		send_request(FN_QUERY,  32'd0, 32'd0, 32'd3020);
		send_request(FN_QUERY,  32'd0, 32'd0, 32'd10020);
		send_request(FN_QUERY,  '1, 32'd0, 32'h10);
		send_request(FN_NOP,    '1, '1, '1);
		send_request(FN_NOP,    32'd0, 32'd0, 32'd0);
		send_request(FN_EXPIRE, 32'd0, 32'd0, 32'd30019);
		send_request(FN_QUERY,  '1, 32'd0, 32'd30019);
		send_request(FN_UPDATE, 32'd5, 32'd1, 32'd30019);
		send_request(FN_UPDATE, '1, 32'd3, 32'd30019);
		send_request(FN_UPDATE, '1, 32'd2, 32'd30019);
		send_request(FN_EXPIRE, 32'd0, 32'd0, 32'd30020);
		send_request(FN_QUERY,  32'd0, 32'd0, 32'd30020);
		clock_ms = 32'd30020;

		random_requests(90);
		drain_results();
		load_thresholds('0, '0, '0);
		random_requests(80);
		drain_results();
		load_thresholds('1, '1, '1);
		random_requests(80);
		drain_results();
		load_thresholds($urandom_range(0, 8000), $urandom_range(8000, 20000),
			$urandom_range(0, 40000));
		random_requests(80);
		drain_results();
		// stale threshold below dim
		load_thresholds(32'd9000, 32'd2000, 32'd15000);
		random_requests(60);
		drain_results();
		idling_on = 1'b0;
		load_thresholds(DIM_RESET, STALE_RESET, EXPIRE_RESET);
		random_requests(60);
		drain_results();
		repeat (30) @(negedge clk);

		if (book.errors == 0 && book.pending_replies.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
